// ===== rtl/core/swqf_pkg.sv =====
// ----------------------------------------------------------------------------
// swqf_pkg
// widths, limits and divider handshake types shared by the window fit core
// ----------------------------------------------------------------------------
package swqf_pkg;

  // window depth and the counters that walk it
  localparam int unsigned WIN    = 64;
  localparam int unsigned ADDR_W = $clog2(WIN);
  localparam int unsigned CNT_W  = $clog2(WIN + 1);

  // sample and coefficient formats
  localparam int unsigned X_W    = 16;
  localparam int unsigned Y_W    = 32;
  localparam int unsigned X2_W   = 32;
  localparam int unsigned COEF_W = 32;

  // one product of the shared multiplier, and its window sum
  localparam int unsigned PROD_W = 64;
  localparam int unsigned SUM_W  = PROD_W + $clog2(WIN);

  // cofactors and determinants: products of three window sums plus carries
  localparam int unsigned DET_W  = 3 * SUM_W + 4;

  // q-format scaling of the quadratic and linear numerators
  localparam int unsigned QA_SHIFT = 16;
  localparam int unsigned QB_SHIFT = 8;

  localparam int unsigned NUM_W  = DET_W + QA_SHIFT;
  localparam int unsigned DIV_W  = DET_W + COEF_W + 2;

  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W - 1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W - 1){1'b1}}};

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DET_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [COEF_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/swqf_if.sv =====
// ----------------------------------------------------------------------------
// swqf_if
// valid/ready channels for samples in and fit results out
// ----------------------------------------------------------------------------
interface swqf_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [swqf_pkg::X_W-1:0] x_value;
  logic signed [swqf_pkg::Y_W-1:0] y_value;

  modport source (output valid, x_value, y_value, input ready);
  modport sink (input valid, x_value, y_value, output ready);
endinterface

interface swqf_out_if;
  logic                               valid;
  logic                               ready;
  logic                               fit_valid;
  logic                               singular;
  logic signed [swqf_pkg::COEF_W-1:0] coef_quadratic;
  logic signed [swqf_pkg::COEF_W-1:0] coef_linear;
  logic signed [swqf_pkg::COEF_W-1:0] coef_constant;

  modport source (output valid, fit_valid, singular, coef_quadratic, coef_linear,
                  coef_constant, input ready);
  modport sink (input valid, fit_valid, singular, coef_quadratic, coef_linear,
                coef_constant, output ready);
endinterface

// ===== rtl/core/sliding_window_quadratic_fit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_quadratic_fit
// least-squares fit of y = a*x^2 + b*x + c over the last WIN samples
// ----------------------------------------------------------------------------
// usage
//   sample_i carries one (x_value, y_value) beat: x in q8.8, y in q16.16.
//   result_o carries one beat per sample: fit_valid, singular and the three
//   saturated q16.16 coefficients.
//   while the window is still filling, a sample gives a zero result that
//   passes through the emit state into the output register.
//   once the window is full, the window sums take seven passes of one
//   32x32 multiplier and one sum adder per sample, the normal equations
//   take 24 bit-serial multiply-accumulates on one wide adder, and the
//   three coefficients go one after another through a single
//   quotient-bit-per-cycle divider.
//   sample_i.ready is high only while idle; one sample is worked at a time.
//   a finished result waits in the output register while the next sample
//   is taken; if the receiver stalls, that later result holds until taken.
//   reset empties the window (fill count and write slot to zero) and drops
//   any pending result; window storage itself is not cleared.
// ----------------------------------------------------------------------------
module sliding_window_quadratic_fit (
  input  logic       clk_i,
  input  logic       rst_ni,
  swqf_in_if.sink    sample_i,
  swqf_out_if.source result_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_PRIME, S_ACC, S_MAC_LOAD, S_MAC_RUN, S_DIV_START, S_DIV_WAIT, S_EMIT
  } state_e;

  // one sum update per step of the accumulate pass
  typedef enum logic [2:0] {
    ST_S1, ST_S2, ST_T1, ST_S3, ST_S4, ST_T2, ST_T0
  } acc_step_e;

  typedef enum logic [3:0] {
    OPA_S1, OPA_S2, OPA_S3, OPA_S4, OPA_C00, OPA_C01, OPA_C02, OPA_C11, OPA_C12, OPA_C22
  } opa_e;

  typedef enum logic [2:0] {
    OPB_S0, OPB_S1, OPB_S2, OPB_S3, OPB_S4, OPB_T0, OPB_T1, OPB_T2
  } opb_e;

  typedef enum logic [3:0] {
    DST_C00, DST_C01, DST_C02, DST_C11, DST_C12, DST_C22, DST_D, DST_DA, DST_DB, DST_DC
  } dst_e;

  typedef enum logic [1:0] {CF_QUAD, CF_LIN, CF_CONST} coef_e;

  typedef struct packed {
    opa_e a;
    opb_e b;
    dst_e dst;
    logic neg;
    logic last;
  } mac_op_t;

  localparam int unsigned DST_COUNT = 10;
  localparam int unsigned OP_COUNT  = 24;
  localparam int unsigned OP_W      = $clog2(OP_COUNT);
  localparam int unsigned BIT_W     = $clog2(swqf_pkg::SUM_W);

  // cofactors of the symmetric normal matrix, then determinant and the
  // three cramer numerators as dot products with cofactor rows
  localparam mac_op_t MAC_PROG [OP_COUNT] = '{
    '{OPA_S2,  OPB_S0, DST_C00, 1'b0, 1'b0},
    '{OPA_S1,  OPB_S1, DST_C00, 1'b1, 1'b1},
    '{OPA_S1,  OPB_S2, DST_C01, 1'b0, 1'b0},
    '{OPA_S3,  OPB_S0, DST_C01, 1'b1, 1'b1},
    '{OPA_S3,  OPB_S1, DST_C02, 1'b0, 1'b0},
    '{OPA_S2,  OPB_S2, DST_C02, 1'b1, 1'b1},
    '{OPA_S4,  OPB_S0, DST_C11, 1'b0, 1'b0},
    '{OPA_S2,  OPB_S2, DST_C11, 1'b1, 1'b1},
    '{OPA_S2,  OPB_S3, DST_C12, 1'b0, 1'b0},
    '{OPA_S4,  OPB_S1, DST_C12, 1'b1, 1'b1},
    '{OPA_S4,  OPB_S2, DST_C22, 1'b0, 1'b0},
    '{OPA_S3,  OPB_S3, DST_C22, 1'b1, 1'b1},
    '{OPA_C00, OPB_S4, DST_D,   1'b0, 1'b0},
    '{OPA_C01, OPB_S3, DST_D,   1'b0, 1'b0},
    '{OPA_C02, OPB_S2, DST_D,   1'b0, 1'b1},
    '{OPA_C00, OPB_T2, DST_DA,  1'b0, 1'b0},
    '{OPA_C01, OPB_T1, DST_DA,  1'b0, 1'b0},
    '{OPA_C02, OPB_T0, DST_DA,  1'b0, 1'b1},
    '{OPA_C01, OPB_T2, DST_DB,  1'b0, 1'b0},
    '{OPA_C11, OPB_T1, DST_DB,  1'b0, 1'b0},
    '{OPA_C12, OPB_T0, DST_DB,  1'b0, 1'b1},
    '{OPA_C02, OPB_T2, DST_DC,  1'b0, 1'b0},
    '{OPA_C12, OPB_T1, DST_DC,  1'b0, 1'b0},
    '{OPA_C22, OPB_T0, DST_DC,  1'b0, 1'b1}
  };

  // control
  state_e                        state_q;
  acc_step_e                     step_q;
  logic [swqf_pkg::ADDR_W-1:0]   idx_q;
  logic [swqf_pkg::ADDR_W-1:0]   slot_q;
  logic [swqf_pkg::CNT_W-1:0]    fill_q;
  logic [OP_W-1:0]               op_q;
  logic [BIT_W-1:0]              bit_q;
  coef_e                         coef_q;

  // pending and delivered result
  logic                              fit_q;
  logic                              sing_q;
  logic signed [swqf_pkg::COEF_W-1:0] quad_q;
  logic signed [swqf_pkg::COEF_W-1:0] lin_q;
  logic signed [swqf_pkg::COEF_W-1:0] const_q;
  logic                              out_valid_q;
  logic                              out_fit_q;
  logic                              out_sing_q;
  logic signed [swqf_pkg::COEF_W-1:0] out_quad_q;
  logic signed [swqf_pkg::COEF_W-1:0] out_lin_q;
  logic signed [swqf_pkg::COEF_W-1:0] out_const_q;

  // sample ring
  logic signed [swqf_pkg::X_W-1:0] x_mem [swqf_pkg::WIN];
  logic signed [swqf_pkg::Y_W-1:0] y_mem [swqf_pkg::WIN];
  logic signed [swqf_pkg::X_W-1:0] rd_x_q;
  logic signed [swqf_pkg::Y_W-1:0] rd_y_q;
  logic                            rd_en;
  logic [swqf_pkg::ADDR_W-1:0]     rd_addr;

  // window sums
  logic signed [swqf_pkg::SUM_W-1:0]  s1_q, s2_q, s3_q, s4_q, t0_q, t1_q, t2_q;
  logic signed [swqf_pkg::X2_W-1:0]   x2_q;
  logic signed [swqf_pkg::PROD_W-1:0] prod_q;
  logic signed [swqf_pkg::Y_W-1:0]    mul_a, mul_b;
  logic signed [swqf_pkg::PROD_W-1:0] prod;
  logic signed [swqf_pkg::SUM_W-1:0]  add_a, add_b, sum_new;

  // bit-serial multiply-accumulate
  logic signed [swqf_pkg::DET_W-1:0] res_q [DST_COUNT];
  logic [swqf_pkg::DET_W-1:0]        acc_q;
  logic [swqf_pkg::DET_W-1:0]        mcand_q;
  logic [swqf_pkg::SUM_W-1:0]        mplier_q;
  mac_op_t                           cur_op;
  logic signed [swqf_pkg::DET_W-1:0] a_val;
  logic signed [swqf_pkg::SUM_W-1:0] b_val;
  logic                              top_bit;
  logic                              sub_eff;
  logic [swqf_pkg::DET_W-1:0]        addend;
  logic [swqf_pkg::DET_W-1:0]        acc_next;

  // divider hookup
  swqf_pkg::div_req_t div_req;
  swqf_pkg::div_rsp_t div_rsp;

  logic                           in_fire;
  logic                           can_load;
  logic [swqf_pkg::CNT_W-1:0]     fill_next;
  logic                           full_next;

  assign sample_i.ready = (state_q == S_IDLE);
  assign in_fire        = sample_i.valid && sample_i.ready;
  assign can_load       = !out_valid_q || result_o.ready;
  assign fill_next      = (fill_q < swqf_pkg::CNT_W'(swqf_pkg::WIN)) ? fill_q + 1'b1 : fill_q;
  assign full_next      = (fill_next == swqf_pkg::CNT_W'(swqf_pkg::WIN));

  // -------------------------------------------------------------------------
  // sample ring: one write on accept, one registered read per window entry during the sums
  // -------------------------------------------------------------------------
  assign rd_en   = (state_q == S_PRIME) ||
                   ((state_q == S_ACC) && (step_q == ST_T0) &&
                    (idx_q != swqf_pkg::ADDR_W'(swqf_pkg::WIN - 1)));
  assign rd_addr = (state_q == S_PRIME) ? '0 : idx_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_mem[slot_q] <= sample_i.x_value;
      y_mem[slot_q] <= sample_i.y_value;
    end
    if (rd_en) begin
      rd_x_q <= x_mem[rd_addr];
      rd_y_q <= y_mem[rd_addr];
    end
  end

  // -------------------------------------------------------------------------
  // accumulate pass: one product and one sum update per step
  // -------------------------------------------------------------------------
  always_comb begin
    case (step_q)
      ST_S1:   begin mul_a = swqf_pkg::Y_W'(rd_x_q); mul_b = swqf_pkg::Y_W'(rd_x_q); end
      ST_S2:   begin mul_a = swqf_pkg::Y_W'(rd_x_q); mul_b = rd_y_q;                 end
      ST_T1:   begin mul_a = x2_q;                   mul_b = swqf_pkg::Y_W'(rd_x_q); end
      ST_S3:   begin mul_a = x2_q;                   mul_b = x2_q;                   end
      ST_S4:   begin mul_a = x2_q;                   mul_b = rd_y_q;                 end
      default: begin mul_a = swqf_pkg::Y_W'(rd_x_q); mul_b = swqf_pkg::Y_W'(rd_x_q); end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (step_q)
      ST_S1:   add_a = s1_q;
      ST_S2:   add_a = s2_q;
      ST_T1:   add_a = t1_q;
      ST_S3:   add_a = s3_q;
      ST_S4:   add_a = s4_q;
      ST_T2:   add_a = t2_q;
      ST_T0:   add_a = t0_q;
      default: add_a = '0;
    endcase
    case (step_q)
      ST_S1:   add_b = swqf_pkg::SUM_W'(rd_x_q);
      ST_T0:   add_b = swqf_pkg::SUM_W'(rd_y_q);
      default: add_b = swqf_pkg::SUM_W'(prod_q);
    endcase
  end

  assign sum_new = add_a + add_b;

  // -------------------------------------------------------------------------
  // normal-equation solve on one wide adder
  // -------------------------------------------------------------------------
  assign cur_op = MAC_PROG[op_q];

  always_comb begin
    case (cur_op.a)
      OPA_S1:  a_val = swqf_pkg::DET_W'(s1_q);
      OPA_S2:  a_val = swqf_pkg::DET_W'(s2_q);
      OPA_S3:  a_val = swqf_pkg::DET_W'(s3_q);
      OPA_S4:  a_val = swqf_pkg::DET_W'(s4_q);
      OPA_C00: a_val = res_q[DST_C00];
      OPA_C01: a_val = res_q[DST_C01];
      OPA_C02: a_val = res_q[DST_C02];
      OPA_C11: a_val = res_q[DST_C11];
      OPA_C12: a_val = res_q[DST_C12];
      OPA_C22: a_val = res_q[DST_C22];
      default: a_val = '0;
    endcase
    case (cur_op.b)
      OPB_S0:  b_val = swqf_pkg::SUM_W'(swqf_pkg::WIN);
      OPB_S1:  b_val = s1_q;
      OPB_S2:  b_val = s2_q;
      OPB_S3:  b_val = s3_q;
      OPB_S4:  b_val = s4_q;
      OPB_T0:  b_val = t0_q;
      OPB_T1:  b_val = t1_q;
      OPB_T2:  b_val = t2_q;
      default: b_val = '0;
    endcase
  end

  // multiplier sign bit carries negative weight
  assign top_bit  = (bit_q == BIT_W'(swqf_pkg::SUM_W - 1));
  assign sub_eff  = mplier_q[0] & (cur_op.neg ^ top_bit);
  assign addend   = mplier_q[0] ? mcand_q : '0;
  assign acc_next = acc_q + (addend ^ {swqf_pkg::DET_W{sub_eff}}) +
                    swqf_pkg::DET_W'(sub_eff);

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_PRIME: begin
        s1_q  <= '0;
        s2_q  <= '0;
        s3_q  <= '0;
        s4_q  <= '0;
        t0_q  <= '0;
        t1_q  <= '0;
        t2_q  <= '0;
        acc_q <= '0;
      end
      S_ACC: begin
        prod_q <= prod;
        if (step_q == ST_S2) begin
          x2_q <= prod_q[swqf_pkg::X2_W-1:0];
        end
        case (step_q)
          ST_S1:   s1_q <= sum_new;
          ST_S2:   s2_q <= sum_new;
          ST_T1:   t1_q <= sum_new;
          ST_S3:   s3_q <= sum_new;
          ST_S4:   s4_q <= sum_new;
          ST_T2:   t2_q <= sum_new;
          ST_T0:   t0_q <= sum_new;
          default: ;
        endcase
      end
      S_MAC_LOAD: begin
        mcand_q  <= a_val;
        mplier_q <= b_val;
      end
      S_MAC_RUN: begin
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        if (top_bit && cur_op.last) begin
          res_q[cur_op.dst] <= acc_next;
          acc_q             <= '0;
        end else begin
          acc_q <= acc_next;
        end
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------------------------
  // coefficient division
  // -------------------------------------------------------------------------
  always_comb begin
    div_req.start = (state_q == S_DIV_START);
    div_req.den   = res_q[DST_D];
    case (coef_q)
      CF_QUAD: div_req.num = swqf_pkg::NUM_W'(res_q[DST_DA]) <<< swqf_pkg::QA_SHIFT;
      CF_LIN:  div_req.num = swqf_pkg::NUM_W'(res_q[DST_DB]) <<< swqf_pkg::QB_SHIFT;
      default: div_req.num = swqf_pkg::NUM_W'(res_q[DST_DC]);
    endcase
  end

  swqf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // -------------------------------------------------------------------------
  // sequencer and output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= ST_S1;
      idx_q       <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
      op_q        <= '0;
      bit_q       <= '0;
      coef_q      <= CF_QUAD;
      fit_q       <= 1'b0;
      sing_q      <= 1'b0;
      quad_q      <= '0;
      lin_q       <= '0;
      const_q     <= '0;
      out_valid_q <= 1'b0;
      out_fit_q   <= 1'b0;
      out_sing_q  <= 1'b0;
      out_quad_q  <= '0;
      out_lin_q   <= '0;
      out_const_q <= '0;
    end else begin
      // the emit state loads its own beat when the register frees up
      if (out_valid_q && result_o.ready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            slot_q  <= (slot_q == swqf_pkg::ADDR_W'(swqf_pkg::WIN - 1)) ? '0
                                                                         : slot_q + 1'b1;
            fill_q  <= fill_next;
            fit_q   <= full_next;
            sing_q  <= 1'b0;
            quad_q  <= '0;
            lin_q   <= '0;
            const_q <= '0;
            state_q <= full_next ? S_PRIME : S_EMIT;
          end
        end
        S_PRIME: begin
          idx_q   <= '0;
          step_q  <= ST_S1;
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (step_q == ST_T0) begin
            step_q <= ST_S1;
            if (idx_q == swqf_pkg::ADDR_W'(swqf_pkg::WIN - 1)) begin
              op_q    <= '0;
              state_q <= S_MAC_LOAD;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end else begin
            step_q <= acc_step_e'(step_q + 3'd1);
          end
        end
        S_MAC_LOAD: begin
          bit_q   <= '0;
          state_q <= S_MAC_RUN;
        end
        S_MAC_RUN: begin
          bit_q <= bit_q + 1'b1;
          if (top_bit) begin
            if (cur_op.last && (cur_op.dst == DST_D) && (acc_next == '0)) begin
              // fewer than three distinct abscissas
              sing_q  <= 1'b1;
              state_q <= S_EMIT;
            end else if (op_q == OP_W'(OP_COUNT - 1)) begin
              coef_q  <= CF_QUAD;
              state_q <= S_DIV_START;
            end else begin
              op_q    <= op_q + 1'b1;
              state_q <= S_MAC_LOAD;
            end
          end
        end
        S_DIV_START: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            case (coef_q)
              CF_QUAD: quad_q  <= $signed(div_rsp.quot);
              CF_LIN:  lin_q   <= $signed(div_rsp.quot);
              default: const_q <= $signed(div_rsp.quot);
            endcase
            if (coef_q == CF_CONST) begin
              state_q <= S_EMIT;
            end else begin
              coef_q  <= coef_e'(coef_q + 2'd1);
              state_q <= S_DIV_START;
            end
          end
        end
        S_EMIT: begin
          if (can_load) begin
            out_valid_q <= 1'b1;
            out_fit_q   <= fit_q;
            out_sing_q  <= sing_q;
            out_quad_q  <= quad_q;
            out_lin_q   <= lin_q;
            out_const_q <= const_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.fit_valid      = out_fit_q;
  assign result_o.singular       = out_sing_q;
  assign result_o.coef_quadratic = out_quad_q;
  assign result_o.coef_linear    = out_lin_q;
  assign result_o.coef_constant  = out_const_q;

`ifndef NO_ASSERTIONS
  // an accepted beat always leaves the block busy in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("sample accepted but sequencer stayed idle");

  // results are only loaded from the emit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result raised outside emit");

  // a partial window gives a clean zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_fit_q) |->
      (!out_sing_q && (out_quad_q == '0) && (out_lin_q == '0) && (out_const_q == '0)))
    else $error("partial window result not zero");

  // the divider answers only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV_WAIT))
    else $error("divider done out of sequence");
`endif

endmodule

// ===== rtl/core/swqf_div.sv =====
// ----------------------------------------------------------------------------
// swqf_div
// rounding, saturating signed division, one quotient bit per cycle while stepping
// ----------------------------------------------------------------------------
module swqf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swqf_pkg::div_req_t req_i,
  output swqf_pkg::div_rsp_t rsp_o
);

  typedef enum logic [2:0] {D_IDLE, D_PREP, D_CHECK, D_STEP, D_FIN} dstate_e;

  localparam int unsigned BIT_W = $clog2(swqf_pkg::COEF_W);

  dstate_e                         state_q;
  logic [BIT_W-1:0]                cnt_q;
  logic                            neg_q;
  logic                            done_q;
  logic [swqf_pkg::COEF_W-1:0]     quot_q;
  logic [swqf_pkg::COEF_W-1:0]     q_q;
  logic [swqf_pkg::DIV_W-1:0]      rem_q;
  logic [swqf_pkg::DIV_W-1:0]      dv_q;

  logic signed [swqf_pkg::NUM_W-1:0] num_s;
  logic signed [swqf_pkg::DET_W-1:0] den_s;
  logic [swqf_pkg::NUM_W-1:0]        num_mag;
  logic [swqf_pkg::DET_W-1:0]        den_mag;
  logic                              ge;
  logic [swqf_pkg::COEF_W-1:0]       q_final;

  assign num_s   = $signed(req_i.num);
  assign den_s   = $signed(req_i.den);
  assign num_mag = num_s[swqf_pkg::NUM_W-1] ? swqf_pkg::NUM_W'(-num_s)
                                            : swqf_pkg::NUM_W'(num_s);
  assign den_mag = den_s[swqf_pkg::DET_W-1] ? swqf_pkg::DET_W'(-den_s)
                                            : swqf_pkg::DET_W'(den_s);
  assign ge      = (rem_q >= dv_q);

  // ties already folded in by the 2n + d numerator
  always_comb begin
    if (neg_q) begin
      q_final = (q_q > swqf_pkg::COEF_MIN) ? swqf_pkg::COEF_MIN : (~q_q + 1'b1);
    end else begin
      q_final = q_q[swqf_pkg::COEF_W-1] ? swqf_pkg::COEF_MAX : q_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
      done_q  <= 1'b0;
      quot_q  <= '0;
      q_q     <= '0;
    end else begin
      done_q <= (state_q == D_FIN) || ((state_q == D_CHECK) && ge);
      unique case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            neg_q   <= num_s[swqf_pkg::NUM_W-1] ^ den_s[swqf_pkg::DET_W-1];
            state_q <= D_PREP;
          end
        end
        D_PREP: begin
          state_q <= D_CHECK;
        end
        D_CHECK: begin
          cnt_q <= '0;
          q_q   <= '0;
          if (ge) begin
            quot_q  <= neg_q ? swqf_pkg::COEF_MIN : swqf_pkg::COEF_MAX;
            state_q <= D_IDLE;
          end else begin
            state_q <= D_STEP;
          end
        end
        D_STEP: begin
          q_q   <= {q_q[swqf_pkg::COEF_W-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == BIT_W'(swqf_pkg::COEF_W - 1)) begin
            state_q <= D_FIN;
          end
        end
        D_FIN: begin
          quot_q  <= q_final;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  // remainder and shifted divisor
  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          rem_q <= swqf_pkg::DIV_W'(num_mag) << 1;
          dv_q  <= swqf_pkg::DIV_W'(den_mag);
        end
      end
      D_PREP: begin
        rem_q <= rem_q + dv_q;
        dv_q  <= dv_q << (swqf_pkg::COEF_W + 1);
      end
      D_CHECK: begin
        dv_q <= dv_q >> 1;
      end
      D_STEP: begin
        if (ge) begin
          rem_q <= rem_q - dv_q;
        end
        dv_q <= dv_q >> 1;
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule
